// ===== hdl/arpr_pkg.sv =====
package arpr_pkg;

    localparam int FRAME_BYTES       = 64;
    localparam int ADDR_W            = $clog2(FRAME_BYTES);
    localparam int CNT_W             = ADDR_W + 1;
    localparam int ARP_OFFSET        = 14;
    localparam int VLAN_EXTRA        = 4;
    localparam int SOURCE_MAC_OFFSET = 6;
    localparam int MAC_LEN           = 6;
    localparam int IP_LEN            = 4;
    localparam int ARP_BODY_LEN      = 'h1c;
    localparam int PAD_LEN           = 18;
    localparam int SENDER_OFF        = 'h08;
    localparam int TARGET_OFF        = 'h12;
    localparam int TARGET_IP_OFF     = 24;
    localparam int OPCODE_LO_OFF     = 7;
    localparam int PLEN_OFF          = 5;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HLEN_ETH   = 8'h06;
    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [15:0] OP_REPLY   = 16'h0002;

    typedef logic [1:0] t_verdict;
    localparam t_verdict V_REPLY    = 2'd0;
    localparam t_verdict V_NOT_OURS = 2'd1;
    localparam t_verdict V_BAD_LEN  = 2'd2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_VLAN_ENABLE = 2'd0;
    localparam t_cfg_index CFG_OWN_IP      = 2'd1;
    localparam t_cfg_index CFG_OWN_MAC     = 2'd2;

    typedef struct packed {
        t_verdict         verdict;
        logic [CNT_W-1:0] len;
        logic             vlan;
        logic             bcast;
    } t_job;

    function automatic logic [CNT_W-1:0] arp_origin(input logic vlan);
        return vlan ? CNT_W'(ARP_OFFSET + VLAN_EXTRA) : CNT_W'(ARP_OFFSET);
    endfunction

    function automatic logic [7:0] hdr_expect(input logic [2:0] off);
        logic [7:0] b;
        unique case (off)
            3'd0: b = HTYPE_ETH[15:8];
            3'd1: b = HTYPE_ETH[7:0];
            3'd2: b = PTYPE_IPV4[15:8];
            3'd3: b = PTYPE_IPV4[7:0];
            3'd4: b = HLEN_ETH;
            3'd5: b = 8'h00;
            3'd6: b = OP_REQUEST[15:8];
            3'd7: b = OP_REQUEST[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/arpr_ram.sv =====
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/arpr_fifo.sv =====
module arpr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arpr_pkg::t_job i_job,
    input  logic          i_pop,
    output arpr_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    arpr_pkg::t_job                    r_mem [arpr_pkg::QUEUE_DEPTH];
    logic [arpr_pkg::QPTR_W-1:0]       r_wptr;
    logic [arpr_pkg::QPTR_W-1:0]       r_rptr;
    logic [arpr_pkg::QCNT_W-1:0]       r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == arpr_pkg::QCNT_W'(arpr_pkg::QUEUE_DEPTH));
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == arpr_pkg::QPTR_W'(arpr_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == arpr_pkg::QPTR_W'(arpr_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end

endmodule

// ===== hdl/arpr_front.sv =====
module arpr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [7:0]                   i_frame_byte,
    input  logic                         i_end_of_frame,
    input  logic                         i_vlan,
    input  logic [31:0]                  i_own_ip,
    input  logic                         i_fifo_full,
    input  logic                         i_reply_done,
    output logic                         o_busy,
    output logic                         o_we,
    output logic [arpr_pkg::ADDR_W-1:0]  o_waddr,
    output logic [7:0]                   o_wdata,
    output logic                         o_push,
    output arpr_pkg::t_job               o_job
);

    localparam int CW = arpr_pkg::CNT_W;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_lock;
    logic [1:0]    r_hdr_ok;
    logic          r_bcast;
    logic [7:0]    r_tip [2][arpr_pkg::IP_LEN];

    logic          accept;
    logic          room;
    logic [CW-1:0] pos;
    logic [CW-1:0] off [2];
    logic [1:0]    in_arp;
    logic [1:0]    tip_we;
    logic [1:0]    n_hdr_ok;
    logic          n_bcast;
    logic [CW-1:0] len;
    logic [CW-1:0] min_len;
    logic          ip_ok;

    assign o_busy  = r_lock || i_fifo_full;
    assign accept  = i_start && !o_busy;
    assign room    = !r_count[CW-1];
    assign pos     = {1'b0, r_count[CW-2:0]};
    assign o_we    = accept && room;
    assign o_waddr = r_count[CW-2:0];
    assign o_wdata = i_frame_byte;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            off[j]      = pos - arpr_pkg::arp_origin(j[0]);
            in_arp[j]   = room && (pos >= arpr_pkg::arp_origin(j[0]));
            tip_we[j]   = accept && in_arp[j]
                          && (off[j] >= CW'(arpr_pkg::TARGET_IP_OFF))
                          && (off[j] < CW'(arpr_pkg::TARGET_IP_OFF + arpr_pkg::IP_LEN));
            n_hdr_ok[j] = r_hdr_ok[j];
            if (in_arp[j] && (off[j] < CW'(8)) && (off[j][2:0] != 3'(arpr_pkg::PLEN_OFF))
                && (i_frame_byte != arpr_pkg::hdr_expect(off[j][2:0]))) begin
                n_hdr_ok[j] = 1'b0;
            end
        end
        n_bcast = r_bcast;
        if (room && (pos >= CW'(arpr_pkg::SOURCE_MAC_OFFSET))
            && (pos < CW'(arpr_pkg::SOURCE_MAC_OFFSET + arpr_pkg::MAC_LEN))
            && (i_frame_byte != 8'hff)) begin
            n_bcast = 1'b0;
        end
    end

    assign len     = r_count + CW'(room);
    assign min_len = arpr_pkg::arp_origin(i_vlan)
                     + CW'(arpr_pkg::ARP_BODY_LEN + arpr_pkg::PAD_LEN);
    assign ip_ok   = ({r_tip[i_vlan][0], r_tip[i_vlan][1],
                       r_tip[i_vlan][2], r_tip[i_vlan][3]} == i_own_ip);

    always_comb begin
        o_job.len   = len;
        o_job.vlan  = i_vlan;
        o_job.bcast = n_bcast;
        priority if (r_ovf || !room || (len < min_len)) begin
            o_job.verdict = arpr_pkg::V_BAD_LEN;
        end else if (!n_hdr_ok[i_vlan] || !ip_ok) begin
            o_job.verdict = arpr_pkg::V_NOT_OURS;
        end else begin
            o_job.verdict = arpr_pkg::V_REPLY;
        end
    end

    assign o_push = accept && i_end_of_frame;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            if (tip_we[j]) begin
                r_tip[j][2'(off[j] - CW'(arpr_pkg::TARGET_IP_OFF))] <= i_frame_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_lock   <= 1'b0;
            r_hdr_ok <= 2'b11;
            r_bcast  <= 1'b1;
        end else begin
            if (i_reply_done) begin
                r_lock <= 1'b0;
            end
            if (accept) begin
                if (i_end_of_frame) begin
                    r_count  <= '0;
                    r_ovf    <= 1'b0;
                    r_hdr_ok <= 2'b11;
                    r_bcast  <= 1'b1;
                    r_lock   <= (o_job.verdict == arpr_pkg::V_REPLY);
                end else begin
                    r_count  <= len;
                    r_ovf    <= r_ovf || !room;
                    r_hdr_ok <= n_hdr_ok;
                    r_bcast  <= n_bcast;
                end
            end
        end
    end

endmodule

// ===== hdl/arpr_back.sv =====
module arpr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fifo_empty,
    input  arpr_pkg::t_job               i_job,
    input  logic [31:0]                  i_own_ip,
    input  logic [47:0]                  i_own_mac,
    input  logic [7:0]                   i_rdata,
    output logic                         o_pop,
    output logic [arpr_pkg::ADDR_W-1:0]  o_raddr,
    output logic                         o_reply_done,
    output logic                         o_valid,
    output logic [7:0]                   o_reply_byte,
    output logic                         o_last_of_reply,
    output arpr_pkg::t_verdict           o_verdict
);

    localparam int CW = arpr_pkg::CNT_W;
    localparam int AW = arpr_pkg::ADDR_W;

    localparam logic [2:0] K_MEM   = 3'd0;
    localparam logic [2:0] K_SHIFT = 3'd1;
    localparam logic [2:0] K_MAC   = 3'd2;
    localparam logic [2:0] K_IP    = 3'd3;
    localparam logic [2:0] K_ZERO  = 3'd4;
    localparam logic [2:0] K_OP    = 3'd5;

    logic               r_active;
    logic [AW-1:0]      r_idx;
    logic [CW-1:0]      r_len;
    logic               r_vlan;
    logic               r_bcast;

    logic               r_s_valid;
    logic [2:0]         r_s_kind;
    logic [2:0]         r_s_k;
    logic               r_s_last;
    arpr_pkg::t_verdict r_s_verdict;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    arpr_pkg::t_verdict r_out_verdict;

    logic [CW-1:0]      idx;
    logic [CW-1:0]      st;
    logic [CW-1:0]      off;
    logic               issue_last;
    logic [2:0]         kind;
    logic [2:0]         k;
    logic [7:0]         n_byte;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] sel);
        logic [7:0] b;
        unique case (sel)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            default: b = mac[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0: b = ip[31:24];
            2'd1: b = ip[23:16];
            2'd2: b = ip[15:8];
            2'd3: b = ip[7:0];
        endcase
        return b;
    endfunction

    assign idx        = {1'b0, r_idx};
    assign st         = arpr_pkg::arp_origin(r_vlan);
    assign off        = idx - st;
    assign issue_last = ((idx + 1'b1) == r_len);
    assign o_pop      = !r_active && !i_fifo_empty;

    always_comb begin
        kind    = K_MEM;
        k       = 3'd0;
        o_raddr = r_idx;
        priority if (r_bcast && (idx >= CW'(arpr_pkg::SOURCE_MAC_OFFSET))
                     && (idx < CW'(arpr_pkg::SOURCE_MAC_OFFSET + arpr_pkg::MAC_LEN))) begin
            kind = K_MAC;
            k    = 3'(idx - CW'(arpr_pkg::SOURCE_MAC_OFFSET));
        end else if (idx < st) begin
            kind = K_MEM;
        end else if (off == CW'(arpr_pkg::OPCODE_LO_OFF)) begin
            kind = K_OP;
        end else if ((off >= CW'(arpr_pkg::SENDER_OFF))
                     && (off < CW'(arpr_pkg::SENDER_OFF + arpr_pkg::MAC_LEN))) begin
            kind = K_MAC;
            k    = 3'(off - CW'(arpr_pkg::SENDER_OFF));
        end else if ((off >= CW'(arpr_pkg::SENDER_OFF + arpr_pkg::MAC_LEN))
                     && (off < CW'(arpr_pkg::TARGET_OFF))) begin
            kind = K_IP;
            k    = 3'(off - CW'(arpr_pkg::SENDER_OFF + arpr_pkg::MAC_LEN));
        end else if ((off >= CW'(arpr_pkg::TARGET_OFF))
                     && (off < CW'(arpr_pkg::ARP_BODY_LEN))) begin
            kind    = K_SHIFT;
            o_raddr = AW'(r_idx - AW'(arpr_pkg::TARGET_OFF - arpr_pkg::SENDER_OFF));
        end else if ((off >= CW'(arpr_pkg::ARP_BODY_LEN))
                     && (off < CW'(arpr_pkg::ARP_BODY_LEN + arpr_pkg::PAD_LEN))) begin
            kind = K_ZERO;
        end else begin
            kind = K_MEM;
        end
    end

    always_comb begin
        unique case (r_s_kind)
            K_MEM, K_SHIFT: n_byte = i_rdata;
            K_MAC:          n_byte = mac_byte(i_own_mac, r_s_k);
            K_IP:           n_byte = ip_byte(i_own_ip, r_s_k[1:0]);
            K_OP:           n_byte = arpr_pkg::OP_REPLY[7:0];
            default:        n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_len   <= i_job.len;
            r_vlan  <= i_job.vlan;
            r_bcast <= i_job.bcast;
        end
        if (r_active) begin
            r_s_kind    <= kind;
            r_s_k       <= k;
            r_s_last    <= issue_last;
            r_s_verdict <= arpr_pkg::V_REPLY;
        end else begin
            r_s_kind    <= K_ZERO;
            r_s_k       <= 3'd0;
            r_s_last    <= 1'b1;
            r_s_verdict <= i_job.verdict;
        end
        r_out_byte    <= n_byte;
        r_out_last    <= r_s_last;
        r_out_verdict <= r_s_verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s_valid;
            if (r_active) begin
                r_s_valid <= 1'b1;
                r_idx     <= r_idx + 1'b1;
                if (issue_last) begin
                    r_active <= 1'b0;
                end
            end else if (o_pop) begin
                r_s_valid <= (i_job.verdict != arpr_pkg::V_REPLY);
                r_active  <= (i_job.verdict == arpr_pkg::V_REPLY);
                r_idx     <= '0;
            end else begin
                r_s_valid <= 1'b0;
            end
        end
    end

    assign o_reply_done    = r_s_valid && r_s_last && (r_s_verdict == arpr_pkg::V_REPLY);
    assign o_valid         = r_out_valid;
    assign o_reply_byte    = r_out_byte;
    assign o_last_of_reply = r_out_last;
    assign o_verdict       = r_out_verdict;

endmodule

// ===== hdl/arp_request_responder_unit.sv =====
// ARP request responder.
// Input: one frame byte per transfer, taken at a clock edge with start high and
// busy low; i_end_of_frame marks the final byte. Bytes are written into a
// 64-byte frame store while the header fields are checked on the fly.
// Output: each result is shown for one cycle with o_valid high; the receiver
// cannot hold results off. A matching ARP request yields the whole frame,
// rewritten as a reply, one byte per cycle with o_verdict 0 and
// o_last_of_reply on the final byte. Any other frame yields one result with
// reply byte 0 and verdict 1 (not for us) or 2 (too short or too long).
// Timing: with the back end idle, a result passes the job queue, the stage
// register and the output register; reply bytes are also read through the
// single, registered read port of the frame store and stream back to back.
// Frame bytes enter at one per cycle while busy is low; busy is held
// from the end of a frame that earns a reply until its last byte is on the
// result ports, and while the two-entry job queue is full.
// Configuration: i_cfg_valid/o_cfg_ready write vlan_enable (0), own_ip (1),
// own_mac (2); the user must write them only while the block is idle, which
// the block does not enforce. Reset clears the configuration registers and
// frame counters, not the frame store: a reply only reads its own frame.
module arp_request_responder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_end_of_frame,
    output logic        o_valid,
    output logic [7:0]  o_reply_byte,
    output logic        o_last_of_reply,
    output logic [1:0]  o_verdict,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic                        r_vlan;
    logic [31:0]                 r_own_ip;
    logic [47:0]                 r_own_mac;

    logic                        fifo_full;
    logic                        fifo_empty;
    logic                        push;
    logic                        pop;
    arpr_pkg::t_job              push_job;
    arpr_pkg::t_job              pop_job;
    logic                        reply_done;
    logic                        we;
    logic [arpr_pkg::ADDR_W-1:0] waddr;
    logic [7:0]                  wdata;
    logic [arpr_pkg::ADDR_W-1:0] raddr;
    logic [7:0]                  rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlan    <= 1'b0;
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                arpr_pkg::CFG_VLAN_ENABLE: r_vlan    <= i_cfg_data[0];
                arpr_pkg::CFG_OWN_IP:      r_own_ip  <= i_cfg_data[31:0];
                arpr_pkg::CFG_OWN_MAC:     r_own_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    arpr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_vlan         (r_vlan),
        .i_own_ip       (r_own_ip),
        .i_fifo_full    (fifo_full),
        .i_reply_done   (reply_done),
        .o_busy         (busy),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_push         (push),
        .o_job          (push_job)
    );

    arpr_ram #(
        .WIDTH (8),
        .DEPTH (arpr_pkg::FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    arpr_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    arpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fifo_empty    (fifo_empty),
        .i_job           (pop_job),
        .i_own_ip        (r_own_ip),
        .i_own_mac       (r_own_mac),
        .i_rdata         (rdata),
        .o_pop           (pop),
        .o_raddr         (raddr),
        .o_reply_done    (reply_done),
        .o_valid         (o_valid),
        .o_reply_byte    (o_reply_byte),
        .o_last_of_reply (o_last_of_reply),
        .o_verdict       (o_verdict)
    );

endmodule

// ===== hdl/arpr_checker.sv =====
module arpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_end_of_frame,
    input logic        o_valid,
    input logic [7:0]  o_reply_byte,
    input logic        o_last_of_reply,
    input logic [1:0]  o_verdict
);

    a_reply_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_reply |=> o_valid && (o_verdict == arpr_pkg::V_REPLY))
        else $error("reply stream broken before its last byte");

    a_ignore_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_verdict != arpr_pkg::V_REPLY) |-> o_last_of_reply)
        else $error("ignore result not marked last");

    a_ignore_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_verdict != arpr_pkg::V_REPLY) |-> (o_reply_byte == 8'h00))
        else $error("ignore result carries a nonzero byte");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start) && $past(i_end_of_frame))
        else $error("busy raised without a frame end transfer");

endmodule

bind arp_request_responder_unit arpr_checker u_checker (.*);
